// File: rtl/i2r_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2r_pkg
// Shared types, constants and symbol tables for the integer to Roman
// numeral converter.
// ----------------------------------------------------------------------------
package i2r_pkg;

  // queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  localparam int unsigned ValueW  = 12;
  localparam int unsigned SymbolW = 7;

  localparam logic [ValueW-1:0] MaxValid = 12'd3999;

  // ascii codes of the numeral characters
  localparam logic [SymbolW-1:0] AsciiI = 7'h49;
  localparam logic [SymbolW-1:0] AsciiV = 7'h56;
  localparam logic [SymbolW-1:0] AsciiX = 7'h58;
  localparam logic [SymbolW-1:0] AsciiL = 7'h4C;
  localparam logic [SymbolW-1:0] AsciiC = 7'h43;
  localparam logic [SymbolW-1:0] AsciiD = 7'h44;
  localparam logic [SymbolW-1:0] AsciiM = 7'h4D;
  localparam logic [SymbolW-1:0] AsciiNone = 7'h00;

  // place codes
  localparam logic [1:0] PlaceOnes  = 2'd0;
  localparam logic [1:0] PlaceTens  = 2'd1;
  localparam logic [1:0] PlaceHunds = 2'd2;
  localparam logic [1:0] PlaceThous = 2'd3;

  // which of the one, five, ten symbols of a place is used
  typedef enum logic [1:0] {
    SymOne,
    SymFive,
    SymTen
  } sym_kind_e;

  // classified item as it sits in the queue
  typedef struct packed {
    logic       err;
    logic [1:0] thou;
    logic [3:0] hund;
    logic [6:0] rem;
  } i2r_entry_t;

  // number of characters for one decimal digit
  function automatic logic [2:0] pat_len(logic [3:0] d);
    logic [2:0] len;
    case (d) inside
      4'd1, 4'd5:        len = 3'd1;
      4'd2, 4'd4, 4'd6,
      4'd9:              len = 3'd2;
      4'd3, 4'd7:        len = 3'd3;
      4'd8:              len = 3'd4;
      default:           len = 3'd0;
    endcase
    return len;
  endfunction

  // symbol kind of character pos within the pattern of digit d
  function automatic sym_kind_e sym_kind(logic [3:0] d, logic [1:0] pos);
    sym_kind_e k;
    case (d) inside
      4'd4:                    k = (pos == 2'd0) ? SymOne : SymFive;
      4'd5, 4'd6, 4'd7, 4'd8:  k = (pos == 2'd0) ? SymFive : SymOne;
      4'd9:                    k = (pos == 2'd0) ? SymOne : SymTen;
      default:                 k = SymOne;
    endcase
    return k;
  endfunction

  // ascii character for a place and symbol kind
  function automatic logic [SymbolW-1:0] place_sym(logic [1:0] place, sym_kind_e kind);
    logic [SymbolW-1:0] s;
    s = AsciiNone;
    unique case (place)
      PlaceOnes: begin
        case (kind)
          SymOne:  s = AsciiI;
          SymFive: s = AsciiV;
          SymTen:  s = AsciiX;
          default: s = AsciiNone;
        endcase
      end
      PlaceTens: begin
        case (kind)
          SymOne:  s = AsciiX;
          SymFive: s = AsciiL;
          SymTen:  s = AsciiC;
          default: s = AsciiNone;
        endcase
      end
      PlaceHunds: begin
        case (kind)
          SymOne:  s = AsciiC;
          SymFive: s = AsciiD;
          SymTen:  s = AsciiM;
          default: s = AsciiNone;
        endcase
      end
      PlaceThous: begin
        s = (kind == SymOne) ? AsciiM : AsciiNone;
      end
      default: s = AsciiNone;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// File: rtl/i2r_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2r_front
// Accepts input numbers, flags out-of-range values and splits the value
// into thousands, hundreds and a remainder below one hundred.
// ----------------------------------------------------------------------------
module i2r_front
  import i2r_pkg::*;
(
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [ValueW-1:0] value_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output i2r_entry_t             q_entry_o
);

  logic [1:0]  thou;
  logic [3:0]  hund;
  logic [11:0] rem1000_w;
  logic [9:0]  rem1000;
  logic [9:0]  rem100_w;

  // handshake toward the queue
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // thousands digit by parallel compares, then subtract
  always_comb begin
    thou = 2'd0;
    for (int i = 1; i <= 3; i++) begin
      if (value_i >= 12'(i * 1000)) thou = 2'(i);
    end
    rem1000_w = value_i - 12'(thou) * 12'd1000;
    rem1000   = rem1000_w[9:0];
  end

  // hundreds digit on the remainder below one thousand
  always_comb begin
    hund = 4'd0;
    for (int i = 1; i <= 9; i++) begin
      if (rem1000 >= 10'(i * 100)) hund = 4'(i);
    end
    rem100_w = rem1000 - 10'(hund) * 10'd100;
  end

  // classified entry
  always_comb begin
    q_entry_o.err  = (value_i == '0) || (value_i > MaxValid);
    q_entry_o.thou = thou;
    q_entry_o.hund = hund;
    q_entry_o.rem  = rem100_w[6:0];
  end

endmodule
`default_nettype wire

// File: rtl/i2r_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2r_queue
// Small first-in first-out queue of classified entries between the front
// and the back.
// ----------------------------------------------------------------------------
module i2r_queue
  import i2r_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire i2r_entry_t entry_i,
  input  wire logic       pop_i,
  output i2r_entry_t      entry_o,
  output logic            full_o,
  output logic            empty_o
);

  i2r_entry_t         mem_q [QueueDepth];
  logic [QueueAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueueAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueAw:0]   count_q, count_d;

  assign full_o  = (count_q == (QueueAw+1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) wr_ptr_d = wr_ptr_q + 1'b1;
    if (pop_i)  rd_ptr_d = rd_ptr_q + 1'b1;
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    else if (!push_i && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

endmodule
`default_nettype wire

// File: rtl/i2r_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2r_back
// Walks the decimal digits of one entry and emits one numeral character
// per transfer into an output register.
// ----------------------------------------------------------------------------
module i2r_back
  import i2r_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire i2r_entry_t         q_entry_i,
  input  wire logic               q_empty_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [SymbolW-1:0]      symbol_o,
  output logic                    last_o,
  output logic                    out_of_range_o
);

  logic [3:0] digit_q [4];
  logic [3:0] ld_digit [4];
  logic [1:0] place_q, place_d;
  logic [1:0] pos_q, pos_d;
  logic       busy_q, busy_d;
  logic       err_q, err_d;

  logic               out_valid_q, out_valid_d;
  logic [SymbolW-1:0] symbol_q;
  logic               last_q;
  logic               oor_q;

  logic [3:0] tens;
  logic [6:0] ones_w;
  logic [1:0] top_place;
  logic [1:0] nxt_place;
  logic       lower_nz;
  logic [3:0] cur_d;
  logic [2:0] cur_len;
  logic       dig_end;
  logic       fin;
  logic       emit;
  logic       load;

  // tens and ones of the remainder below one hundred
  always_comb begin
    tens = 4'd0;
    for (int i = 1; i <= 9; i++) begin
      if (q_entry_i.rem >= 7'(i * 10)) tens = 4'(i);
    end
    ones_w = q_entry_i.rem - 7'(tens) * 7'd10;
    ld_digit[PlaceOnes]  = ones_w[3:0];
    ld_digit[PlaceTens]  = tens;
    ld_digit[PlaceHunds] = q_entry_i.hund;
    ld_digit[PlaceThous] = {2'b00, q_entry_i.thou};
  end

  // highest nonzero place of a new entry
  always_comb begin
    top_place = PlaceOnes;
    for (int p = 0; p < 4; p++) begin
      if (ld_digit[p] != 4'd0) top_place = 2'(p);
    end
  end

  // next nonzero place below the current one
  always_comb begin
    nxt_place = PlaceOnes;
    lower_nz  = 1'b0;
    for (int p = 0; p < 4; p++) begin
      if ((2'(p) < place_q) && (digit_q[p] != 4'd0)) begin
        nxt_place = 2'(p);
        lower_nz  = 1'b1;
      end
    end
  end

  // current character
  assign cur_d   = digit_q[place_q];
  assign cur_len = pat_len(cur_d);
  assign dig_end = (({1'b0, pos_q} + 3'd1) == cur_len);
  assign fin     = err_q || (dig_end && !lower_nz);
  assign emit    = busy_q && (!out_valid_q || !out_stall_i);
  assign load    = !q_empty_i && (!busy_q || (emit && fin));
  assign q_pop_o = load;

  // sequencer next state
  always_comb begin
    busy_d  = busy_q;
    err_d   = err_q;
    place_d = place_q;
    pos_d   = pos_q;
    if (load) begin
      busy_d  = 1'b1;
      err_d   = q_entry_i.err;
      place_d = top_place;
      pos_d   = 2'd0;
    end else if (emit) begin
      if (fin) begin
        busy_d = 1'b0;
      end else if (dig_end) begin
        place_d = nxt_place;
        pos_d   = 2'd0;
      end else begin
        pos_d = pos_q + 2'd1;
      end
    end
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      err_q       <= 1'b0;
      place_q     <= PlaceOnes;
      pos_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      err_q       <= err_d;
      place_q     <= place_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // digit lanes and output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int p = 0; p < 4; p++) digit_q[p] <= ld_digit[p];
    end
    if (emit) begin
      symbol_q <= err_q ? AsciiNone : place_sym(place_q, sym_kind(cur_d, pos_q));
      last_q   <= fin;
      oor_q    <= err_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign symbol_o       = symbol_q;
  assign last_o         = last_q;
  assign out_of_range_o = oor_q;

endmodule
`default_nettype wire

// File: rtl/integer_to_roman_numeral_top.sv
`default_nettype none
// Path: a number accepted into the queue is loaded into the back sequencer's digit
//   lanes, and each of its characters then passes through the output register.
// Throughput: one character per cycle when the output does not stall, set by the
//   back sequencer and its output register; a number yields as many characters as
//   its numeral has (1 to 15), an out-of-range number yields one.
// Reset: asynchronous active low; clears the queue, the sequencer and output valid.
// ----------------------------------------------------------------------------
// integer_to_roman_numeral_top
// Converts a 12-bit number to its Roman numeral, one ascii character per
// output transfer, with the final one marked and invalid values flagged.
// ----------------------------------------------------------------------------
module integer_to_roman_numeral_top
  import i2r_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [ValueW-1:0]  value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [SymbolW-1:0]      symbol_o,
  output logic                    last_o,
  output logic                    out_of_range_o
);

  i2r_entry_t push_entry;
  i2r_entry_t head_entry;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;

  // classify and split
  i2r_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (push_entry)
  );

  // decoupling queue
  i2r_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .pop_i   (q_pop),
    .entry_o (head_entry),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // character sequencer
  i2r_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_entry_i      (head_entry),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .symbol_o       (symbol_o),
    .last_o         (last_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule
`default_nettype wire
